// File: hdl/dce_pkg.sv
`timescale 1ns / 1ps
package dce_pkg;

  localparam int EPS_W  = 36;
  localparam int MINP_W = 11;
  localparam logic [EPS_W-1:0]  EPS_RESET  = 36'd147456;
  localparam logic [MINP_W-1:0] MINP_RESET = 11'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] KIND_REGULAR = 2'd0;
  localparam logic [1:0] KIND_NOISE   = 2'd1;
  localparam logic [1:0] KIND_UNCL    = 2'd2;

  localparam logic ADDR_EPS  = 1'b0;
  localparam logic ADDR_MINP = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_POUT, S_PCHK, S_RD, S_DIF, S_SQ, S_CMP,
    S_PEVAL, S_QPOP, S_QRD, S_QLAT, S_QEVAL, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_PCOUNT, M_SEED, M_QCOUNT, M_EXPAND
  } mode_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLR_STEP, OP_P_READ, OP_P_LATCH, OP_P_SKIP, OP_SCAN_RD, OP_SCAN_DIF,
    OP_SCAN_SQ, OP_SCAN_CMP, OP_P_NOISE, OP_SEED_START, OP_Q_POP, OP_Q_READ,
    OP_Q_LATCH, OP_EXP_START, OP_CL_DONE
  } op_t;

  typedef struct packed {
    logic  acc;
    cmd_t  cmd;
    op_t   op;
    mode_t mode;
  } ctrl_t;

  typedef struct packed {
    logic i_last;
    logic p_end;
    logic lab_uncl;
    logic core;
    logic q_empty;
    logic empty;
  } stat_t;

endpackage

// File: hdl/dce_regs.sv
`timescale 1ns / 1ps
module dce_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output logic [dce_pkg::EPS_W-1:0]  eps_r,
  output logic [dce_pkg::MINP_W-1:0] minp_r
);

  logic                       wr;
  logic [dce_pkg::EPS_W-1:0]  eps_nxt;
  logic [dce_pkg::MINP_W-1:0] minp_nxt;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    eps_nxt  = eps_r;
    minp_nxt = minp_r;
    if (wr && paddr[3] == dce_pkg::ADDR_EPS) eps_nxt = pwdata[dce_pkg::EPS_W-1:0];
    if (wr && paddr[3] == dce_pkg::ADDR_MINP) minp_nxt = pwdata[dce_pkg::MINP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= dce_pkg::EPS_RESET;
      minp_r <= dce_pkg::MINP_RESET;
    end else begin
      eps_r  <= eps_nxt;
      minp_r <= minp_nxt;
    end
  end

  assign prdata = (paddr[3] == dce_pkg::ADDR_MINP) ? 64'(minp_r) : 64'(eps_r);

endmodule

// File: hdl/dce_ctrl.sv
`timescale 1ns / 1ps
module dce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     in_command,
  input  dce_pkg::stat_t stat,
  output dce_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           out_valid
);

  dce_pkg::state_t state_r, state_nxt;
  dce_pkg::mode_t  mode_r, mode_nxt;
  logic            resp_r, resp_nxt;
  logic            acc;
  dce_pkg::cmd_t   cmd;

  assign cmd = dce_pkg::cmd_t'(in_command);
  assign acc = start && (state_r == dce_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    resp_nxt  = acc && (cmd != dce_pkg::CMD_RUN);
    case (state_r)
      dce_pkg::S_IDLE: begin
        if (acc && cmd == dce_pkg::CMD_RUN)
          state_nxt = stat.empty ? dce_pkg::S_DONE : dce_pkg::S_CLR;
      end
      dce_pkg::S_CLR: if (stat.i_last) state_nxt = dce_pkg::S_POUT;
      dce_pkg::S_POUT: state_nxt = stat.p_end ? dce_pkg::S_DONE : dce_pkg::S_PCHK;
      dce_pkg::S_PCHK: begin
        if (stat.lab_uncl) begin
          state_nxt = dce_pkg::S_RD;
          mode_nxt  = dce_pkg::M_PCOUNT;
        end else begin
          state_nxt = dce_pkg::S_POUT;
        end
      end
      dce_pkg::S_RD:  state_nxt = dce_pkg::S_DIF;
      dce_pkg::S_DIF: state_nxt = dce_pkg::S_SQ;
      dce_pkg::S_SQ:  state_nxt = dce_pkg::S_CMP;
      dce_pkg::S_CMP: begin
        if (!stat.i_last) begin
          state_nxt = dce_pkg::S_RD;
        end else begin
          case (mode_r)
            dce_pkg::M_PCOUNT: state_nxt = dce_pkg::S_PEVAL;
            dce_pkg::M_QCOUNT: state_nxt = dce_pkg::S_QEVAL;
            default:           state_nxt = dce_pkg::S_QPOP;
          endcase
        end
      end
      dce_pkg::S_PEVAL: begin
        if (stat.core) begin
          state_nxt = dce_pkg::S_RD;
          mode_nxt  = dce_pkg::M_SEED;
        end else begin
          state_nxt = dce_pkg::S_POUT;
        end
      end
      dce_pkg::S_QPOP: state_nxt = stat.q_empty ? dce_pkg::S_POUT : dce_pkg::S_QRD;
      dce_pkg::S_QRD:  state_nxt = dce_pkg::S_QLAT;
      dce_pkg::S_QLAT: begin
        state_nxt = dce_pkg::S_RD;
        mode_nxt  = dce_pkg::M_QCOUNT;
      end
      dce_pkg::S_QEVAL: begin
        if (stat.core) begin
          state_nxt = dce_pkg::S_RD;
          mode_nxt  = dce_pkg::M_EXPAND;
        end else begin
          state_nxt = dce_pkg::S_QPOP;
        end
      end
      dce_pkg::S_DONE: state_nxt = dce_pkg::S_IDLE;
      default:         state_nxt = dce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.acc  = acc;
    ctrl.cmd  = cmd;
    ctrl.mode = mode_r;
    ctrl.op   = dce_pkg::OP_NOP;
    case (state_r)
      dce_pkg::S_CLR:  ctrl.op = dce_pkg::OP_CLR_STEP;
      dce_pkg::S_POUT: if (!stat.p_end) ctrl.op = dce_pkg::OP_P_READ;
      dce_pkg::S_PCHK: ctrl.op = stat.lab_uncl ? dce_pkg::OP_P_LATCH : dce_pkg::OP_P_SKIP;
      dce_pkg::S_RD:   ctrl.op = dce_pkg::OP_SCAN_RD;
      dce_pkg::S_DIF:  ctrl.op = dce_pkg::OP_SCAN_DIF;
      dce_pkg::S_SQ:   ctrl.op = dce_pkg::OP_SCAN_SQ;
      dce_pkg::S_CMP:  ctrl.op = dce_pkg::OP_SCAN_CMP;
      dce_pkg::S_PEVAL:
        ctrl.op = stat.core ? dce_pkg::OP_SEED_START : dce_pkg::OP_P_NOISE;
      dce_pkg::S_QPOP: ctrl.op = stat.q_empty ? dce_pkg::OP_CL_DONE : dce_pkg::OP_Q_POP;
      dce_pkg::S_QRD:  ctrl.op = dce_pkg::OP_Q_READ;
      dce_pkg::S_QLAT: ctrl.op = dce_pkg::OP_Q_LATCH;
      dce_pkg::S_QEVAL: if (stat.core) ctrl.op = dce_pkg::OP_EXP_START;
      default:         ctrl.op = dce_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dce_pkg::S_IDLE;
      mode_r  <= dce_pkg::M_PCOUNT;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      resp_r  <= resp_nxt;
    end
  end

  assign busy      = (state_r != dce_pkg::S_IDLE);
  assign out_valid = resp_r || (state_r == dce_pkg::S_DONE);

endmodule

// File: hdl/dce_datapath.sv
`timescale 1ns / 1ps
module dce_datapath #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dce_pkg::ctrl_t             ctrl,
  output dce_pkg::stat_t             stat,
  input  logic [15:0]                in_x_coord,
  input  logic [15:0]                in_y_coord,
  input  logic [9:0]                 in_point_index,
  input  logic [dce_pkg::EPS_W-1:0]  eps_r,
  input  logic [dce_pkg::MINP_W-1:0] minp_r,
  output logic [1:0]                 out_status,
  output logic [1:0]                 out_label_kind,
  output logic [9:0]                 out_cluster_number,
  output logic [10:0]                out_cluster_count,
  output logic [10:0]                out_point_count
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int LW    = IDX_W + 2;
  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int SQW   = 2 * DW;
  localparam int SUMW  = SQW + 1;
  localparam int EW    = (SUMW > dce_pkg::EPS_W) ? SUMW : dce_pkg::EPS_W;
  localparam int MW    = (CNT_W > dce_pkg::MINP_W) ? CNT_W : dce_pkg::MINP_W;
  localparam int PW    = (CNT_W > 10) ? CNT_W : 10;
  localparam int OW    = (CNT_W > 11) ? CNT_W : 11;
  localparam int NW    = (IDX_W > 10) ? IDX_W : 10;

  logic [CW-1:0] x_mem [MAX_POINTS];
  logic [CW-1:0] y_mem [MAX_POINTS];
  logic [LW-1:0] lab_mem [MAX_POINTS];
  logic [IDX_W-1:0] q_mem [MAX_POINTS];

  logic [CW-1:0]    x_q, y_q;
  logic [LW-1:0]    lab_q;
  logic [IDX_W-1:0] q_q;

  logic [CNT_W-1:0] loaded_r, loaded_nxt, next_cl_r, next_cl_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, p_r, p_nxt, cnt_r, cnt_nxt;
  logic [CNT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [IDX_W-1:0] c_r, c_nxt, cid_r, cid_nxt;
  logic [CW-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic [DW-1:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQW-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             res_read_r, res_read_nxt;

  logic             xy_we, xy_re, lab_we, lab_re, q_we, q_re;
  logic [IDX_W-1:0] xy_wa, xy_ra, lab_wa, lab_ra, q_wa, q_ra;
  logic [CW-1:0]    x_wd, y_wd;
  logic [LW-1:0]    lab_wd;
  logic [IDX_W-1:0] q_wd;

  logic [47:0]      xin_ext, yin_ext;
  logic [PW-1:0]    idx_ext;
  logic             full, range_bad, nb, q_room;
  logic [DW-1:0]    ddx, ddy;
  logic [SUMW-1:0]  dsq;
  logic [1:0]       lab_kind;
  logic [NW-1:0]    num_ext;
  logic [OW-1:0]    ncl_ext, nld_ext;

  assign xin_ext   = {{32{in_x_coord[15]}}, in_x_coord};
  assign yin_ext   = {{32{in_y_coord[15]}}, in_y_coord};
  assign idx_ext   = PW'(in_point_index);
  assign full      = (loaded_r >= CNT_W'(MAX_POINTS));
  assign range_bad = (idx_ext >= PW'(loaded_r));
  assign ddx       = {x_q[CW-1], x_q} - {px_r[CW-1], px_r};
  assign ddy       = {y_q[CW-1], y_q} - {py_r[CW-1], py_r};
  assign dsq       = SUMW'(sx_r) + SUMW'(sy_r);
  assign nb        = (EW'(dsq) < EW'(eps_r));
  assign lab_kind  = lab_q[LW-1:LW-2];
  assign q_room    = (tail_r < CNT_W'(MAX_POINTS));

  assign stat.i_last   = ((i_r + CNT_W'(1)) == loaded_r);
  assign stat.p_end    = (p_r == loaded_r);
  assign stat.lab_uncl = (lab_kind == dce_pkg::KIND_UNCL);
  assign stat.core     = (MW'(cnt_r) >= MW'(minp_r));
  assign stat.q_empty  = (head_r == tail_r);
  assign stat.empty    = (loaded_r == '0);

  always_comb begin
    loaded_nxt     = loaded_r;
    next_cl_nxt    = next_cl_r;
    i_nxt          = i_r;
    p_nxt          = p_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    c_nxt          = c_r;
    cid_nxt        = cid_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    xy_we  = 1'b0;
    xy_re  = 1'b0;
    lab_we = 1'b0;
    lab_re = 1'b0;
    q_we   = 1'b0;
    q_re   = 1'b0;
    xy_wa  = loaded_r[IDX_W-1:0];
    xy_ra  = i_r[IDX_W-1:0];
    lab_wa = i_r[IDX_W-1:0];
    lab_ra = i_r[IDX_W-1:0];
    q_wa   = tail_r[IDX_W-1:0];
    q_ra   = head_r[IDX_W-1:0];
    x_wd   = xin_ext[CW-1:0];
    y_wd   = yin_ext[CW-1:0];
    lab_wd = {dce_pkg::KIND_UNCL, {IDX_W{1'b0}}};
    q_wd   = i_r[IDX_W-1:0];

    if (ctrl.acc) begin
      res_status_nxt = dce_pkg::ST_OK;
      res_read_nxt   = 1'b0;
      case (ctrl.cmd)
        dce_pkg::CMD_LOAD: begin
          if (full) begin
            res_status_nxt = dce_pkg::ST_FULL;
          end else begin
            xy_we      = 1'b1;
            lab_we     = 1'b1;
            lab_wa     = loaded_r[IDX_W-1:0];
            loaded_nxt = loaded_r + CNT_W'(1);
          end
        end
        dce_pkg::CMD_RUN: begin
          next_cl_nxt = '0;
          i_nxt       = '0;
          p_nxt       = '0;
        end
        dce_pkg::CMD_READ: begin
          if (range_bad) begin
            res_status_nxt = dce_pkg::ST_RANGE;
          end else begin
            res_read_nxt = 1'b1;
            lab_re       = 1'b1;
            lab_ra       = idx_ext[IDX_W-1:0];
          end
        end
        default: begin
          loaded_nxt  = '0;
          next_cl_nxt = '0;
        end
      endcase
    end

    case (ctrl.op)
      dce_pkg::OP_CLR_STEP: begin
        lab_we = 1'b1;
        i_nxt  = i_r + CNT_W'(1);
      end
      dce_pkg::OP_P_READ: begin
        xy_re  = 1'b1;
        lab_re = 1'b1;
        xy_ra  = p_r[IDX_W-1:0];
        lab_ra = p_r[IDX_W-1:0];
      end
      dce_pkg::OP_P_LATCH: begin
        px_nxt  = x_q;
        py_nxt  = y_q;
        c_nxt   = p_r[IDX_W-1:0];
        i_nxt   = '0;
        cnt_nxt = '0;
      end
      dce_pkg::OP_P_SKIP: p_nxt = p_r + CNT_W'(1);
      dce_pkg::OP_SCAN_RD: begin
        xy_re  = 1'b1;
        lab_re = 1'b1;
      end
      dce_pkg::OP_SCAN_DIF: begin
        dx_nxt = ddx[DW-1] ? (DW'(0) - ddx) : ddx;
        dy_nxt = ddy[DW-1] ? (DW'(0) - ddy) : ddy;
      end
      dce_pkg::OP_SCAN_SQ: begin
        sx_nxt = SQW'(dx_r) * SQW'(dx_r);
        sy_nxt = SQW'(dy_r) * SQW'(dy_r);
      end
      dce_pkg::OP_SCAN_CMP: begin
        i_nxt  = i_r + CNT_W'(1);
        lab_wd = {dce_pkg::KIND_REGULAR, cid_r};
        case (ctrl.mode)
          dce_pkg::M_SEED: begin
            if (nb) begin
              lab_we = 1'b1;
              if (i_r[IDX_W-1:0] != c_r && q_room) begin
                q_we     = 1'b1;
                tail_nxt = tail_r + CNT_W'(1);
              end
            end
          end
          dce_pkg::M_EXPAND: begin
            if (nb && lab_kind != dce_pkg::KIND_REGULAR) begin
              lab_we = 1'b1;
              if (lab_kind == dce_pkg::KIND_UNCL && q_room) begin
                q_we     = 1'b1;
                tail_nxt = tail_r + CNT_W'(1);
              end
            end
          end
          default: if (nb) cnt_nxt = cnt_r + CNT_W'(1);
        endcase
      end
      dce_pkg::OP_P_NOISE: begin
        lab_we = 1'b1;
        lab_wa = p_r[IDX_W-1:0];
        lab_wd = {dce_pkg::KIND_NOISE, {IDX_W{1'b0}}};
        p_nxt  = p_r + CNT_W'(1);
      end
      dce_pkg::OP_SEED_START: begin
        cid_nxt  = next_cl_r[IDX_W-1:0];
        i_nxt    = '0;
        head_nxt = '0;
        tail_nxt = '0;
      end
      dce_pkg::OP_Q_POP: begin
        q_re     = 1'b1;
        head_nxt = head_r + CNT_W'(1);
      end
      dce_pkg::OP_Q_READ: begin
        xy_re = 1'b1;
        xy_ra = q_q;
        c_nxt = q_q;
      end
      dce_pkg::OP_Q_LATCH: begin
        px_nxt  = x_q;
        py_nxt  = y_q;
        i_nxt   = '0;
        cnt_nxt = '0;
      end
      dce_pkg::OP_EXP_START: i_nxt = '0;
      dce_pkg::OP_CL_DONE: begin
        next_cl_nxt = next_cl_r + CNT_W'(1);
        p_nxt       = p_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (xy_we) begin
      x_mem[xy_wa] <= x_wd;
      y_mem[xy_wa] <= y_wd;
    end
    if (xy_re) begin
      x_q <= x_mem[xy_ra];
      y_q <= y_mem[xy_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    if (lab_re) lab_q <= lab_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      next_cl_r <= '0;
    end else begin
      loaded_r  <= loaded_nxt;
      next_cl_r <= next_cl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    p_r          <= p_nxt;
    cnt_r        <= cnt_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    c_r          <= c_nxt;
    cid_r        <= cid_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    sx_r         <= sx_nxt;
    sy_r         <= sy_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
  end

  assign num_ext = NW'(lab_q[IDX_W-1:0]);
  assign ncl_ext = OW'(next_cl_r);
  assign nld_ext = OW'(loaded_r);

  assign out_status         = res_status_r;
  assign out_label_kind     = res_read_r ? lab_kind : dce_pkg::KIND_REGULAR;
  assign out_cluster_number = (res_read_r && lab_kind == dce_pkg::KIND_REGULAR) ?
                              num_ext[9:0] : 10'd0;
  assign out_cluster_count  = ncl_ext[10:0];
  assign out_point_count    = nld_ext[10:0];

endmodule

// File: hdl/density_clustering_engine_top.sv
`timescale 1ns / 1ps
// load, read and clear: result in the cycle after the beat, one beat per cycle while not busy
// run: clears the labels, then a counting scan per candidate point plus a
// labelling scan per core point; scan states are read, diff, square, compare
// reset: synchronous active-low rst_n clears counts and control, store is empty
// results are strobed for one cycle on out_valid; the receiver cannot stall
module density_clustering_engine_top #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_x_coord,
  input  logic [15:0] in_y_coord,
  input  logic [9:0]  in_point_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_label_kind,
  output logic [9:0]  out_cluster_number,
  output logic [10:0] out_cluster_count,
  output logic [10:0] out_point_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  dce_pkg::ctrl_t             ctrl;
  dce_pkg::stat_t             stat;
  logic [dce_pkg::EPS_W-1:0]  eps_r;
  logic [dce_pkg::MINP_W-1:0] minp_r;

  dce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eps_r   (eps_r),
    .minp_r  (minp_r)
  );

  dce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctrl       (ctrl),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  dce_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_x_coord         (in_x_coord),
    .in_y_coord         (in_y_coord),
    .in_point_index     (in_point_index),
    .eps_r              (eps_r),
    .minp_r             (minp_r),
    .out_status         (out_status),
    .out_label_kind     (out_label_kind),
    .out_cluster_number (out_cluster_number),
    .out_cluster_count  (out_cluster_count),
    .out_point_count    (out_point_count)
  );

endmodule
